[hdl/gaussian_window_smoothing_assert.svh]
// assertion macros shared by the checker of the gaussian window smoothing block
`ifndef GAUSSIAN_WINDOW_SMOOTHING_ASSERT_SVH
`define GAUSSIAN_WINDOW_SMOOTHING_ASSERT_SVH

// same-cycle implication, ignored while reset is high
`define GWS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while reset is high
`define GWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define GWS_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/gws_pkg.sv]
// shared constants, types and weight table of the gaussian window smoothing block
`timescale 1ns / 1ps
`default_nettype none
package gws_pkg;

  localparam int WINDOW_RADIUS     = 5;
  localparam int MAX_WIDTH         = 4096;
  localparam int WEIGHT_SCALE_BITS = 12;

  localparam int SLOTS       = 2 * WINDOW_RADIUS + 1;
  localparam int DIST_MAX    = 2 * WINDOW_RADIUS * WINDOW_RADIUS;
  localparam int RESULT_CAP  = WINDOW_RADIUS + 1;
  localparam int QUEUE_DEPTH = 2;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int W_EFF_W  = COL_W + 1;
  localparam int ROW_W    = 16;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int TAP_W    = $clog2(SLOTS);
  localparam int ADDR_W   = SLOT_W + COL_W;
  localparam int ELEV_W   = 24;
  localparam int CELL_W   = ELEV_W + 1;
  localparam int WGT_W    = WEIGHT_SCALE_BITS + 1;
  localparam int K_W      = $clog2(DIST_MAX + 1);
  localparam int CAP_W    = $clog2(RESULT_CAP + 1);
  localparam int PROD_W   = ELEV_W + WGT_W;
  localparam int SUM_W    = PROD_W + $clog2(SLOTS * SLOTS);
  localparam int WSUM_W   = WGT_W + $clog2(SLOTS * SLOTS);
  localparam int QUO_W    = ELEV_W;
  localparam int NUM_W    = SUM_W + 2;
  localparam int STEP_W   = $clog2(QUO_W);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int IMG_W_W    = 13;
  localparam int IMG_H_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef logic [WGT_W-1:0] weight_tab_t [DIST_MAX+1];

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic [W_EFF_W-1:0] w_eff;
    logic [ROW_W-1:0]   h_eff;
  } geom_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] word;
  } wr_t;

  // exp(-k/9) in q32 by repeated multiplication, rounded to the weight scale
  function automatic weight_tab_t build_weights();
    logic [63:0] t;
    weight_tab_t tab;
    t = 64'd1 << 32;
    for (int k = 0; k <= DIST_MAX; k++) begin
      if (k > 0) t = (t * 64'd3843305601 + (64'd1 << 31)) >> 32;
      tab[k] = WGT_W'((t + (64'd1 << (31 - WEIGHT_SCALE_BITS))) >> (32 - WEIGHT_SCALE_BITS));
    end
    return tab;
  endfunction

  localparam weight_tab_t WEIGHT = build_weights();

  // square of the offset of tap i from the window center
  function automatic logic [K_W-1:0] off_sq(logic [TAP_W-1:0] i);
    logic signed [TAP_W:0] d;
    logic signed [TAP_W:0] a;
    logic [K_W-1:0] m;
    d = signed'({1'b0, i}) - signed'((TAP_W + 1)'(WINDOW_RADIUS));
    a = d[TAP_W] ? -d : d;
    m = K_W'(unsigned'(a));
    return K_W'(m * m);
  endfunction

endpackage
`default_nettype wire

[hdl/gws_queue.sv]
// short command queue between the front and back parts
`timescale 1ns / 1ps
`default_nettype none
module gws_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gws_pkg::cmd_t push_data,
  input  logic          pop,
  output gws_pkg::cmd_t pop_data,
  output logic          full,
  output logic          empty
);
  import gws_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

[hdl/gws_front.sv]
// front part: configuration, input positions, line store writes and result scheduling
`timescale 1ns / 1ps
`default_nettype none
module gws_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [gws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gws_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             action,
  input  logic signed [gws_pkg::ELEV_W-1:0] elevation,
  input  logic                             missing,
  input  logic                             back_reading,
  input  logic                             q_full,
  input  logic                             q_empty,
  output logic                             q_push,
  output gws_pkg::cmd_t                    q_data,
  output gws_pkg::wr_t                     wr,
  output gws_pkg::geom_t                   geom
);
  import gws_pkg::*;

  typedef enum logic {IDLE, EMIT} state_t;

  state_t state;
  logic [IMG_W_W-1:0] image_width;
  logic [IMG_H_W-1:0] image_height;
  logic [COL_W-1:0]   in_col;
  logic [ROW_W-1:0]   in_row;
  logic [SLOT_W-1:0]  in_slot;
  logic [COL_W-1:0]   out_col;
  logic [ROW_W-1:0]   out_row;
  logic [SLOT_W-1:0]  out_slot;
  logic [CAP_W-1:0]   cap;
  logic [CAP_W-1:0]   n;

  logic [31:0]        wv;
  logic [W_EFF_W-1:0] w_m1;
  logic [ROW_W-1:0]   h_m1;
  logic [ROW_W:0]     nr_wide;
  logic [ROW_W-1:0]   nr;
  logic [W_EFF_W-1:0] nc_wide;
  logic [W_EFF_W-1:0] nc;
  logic               ready;
  logic               out_last;
  logic               accept;
  logic               pix_ok;

  always_comb begin
    wv = 32'(image_width);
    if (wv == 32'd0) wv = 32'd1;
    else if (wv > 32'(MAX_WIDTH)) wv = 32'(MAX_WIDTH);
    geom.w_eff = W_EFF_W'(wv);
    geom.h_eff = (image_height == '0) ? ROW_W'(1) : image_height;
  end

  assign w_m1 = geom.w_eff - 1'b1;
  assign h_m1 = geom.h_eff - 1'b1;

  // last input position the result at the output position needs
  always_comb begin
    nr_wide = {1'b0, out_row} + (ROW_W + 1)'(WINDOW_RADIUS);
    nr      = (nr_wide > {1'b0, h_m1}) ? h_m1 : nr_wide[ROW_W-1:0];
    nc_wide = {1'b0, out_col} + W_EFF_W'(WINDOW_RADIUS);
    nc      = (nc_wide > w_m1) ? w_m1 : nc_wide;
    ready   = (nr < in_row) || ((nr == in_row) && (nc < {1'b0, in_col}));
  end

  assign out_last = (out_row == h_m1) && ({1'b0, out_col} == w_m1);

  assign in_stall = !((state == IDLE) && q_empty && !back_reading);
  assign accept   = in_valid && !in_stall;
  assign pix_ok   = (in_row < geom.h_eff);

  assign wr.en   = accept && (action == ACT_PIXEL) && pix_ok;
  assign wr.addr = {in_slot, in_col};
  assign wr.word = {~missing, elevation};

  assign q_push      = (state == EMIT) && (n < cap) && ready && !q_full;
  assign q_data.row  = out_row;
  assign q_data.col  = out_col;
  assign q_data.slot = out_slot;
  assign q_data.last = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      image_width  <= IMG_W_W'(640);
      image_height <= IMG_H_W'(480);
      in_col       <= '0;
      in_row       <= '0;
      in_slot      <= '0;
      out_col      <= '0;
      out_row      <= '0;
      out_slot     <= '0;
      cap          <= '0;
      n            <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data[IMG_W_W-1:0];
        REG_HEIGHT: image_height <= cfg_data[IMG_H_W-1:0];
        default:    image_width  <= image_width;
      endcase
      in_col   <= '0;
      in_row   <= '0;
      in_slot  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_slot <= '0;
      state    <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (accept) begin
            n <= '0;
            if (action == ACT_DRAIN) begin
              cap   <= CAP_W'(1);
              state <= EMIT;
            end else if (pix_ok) begin
              cap   <= CAP_W'(RESULT_CAP);
              state <= EMIT;
              if ({1'b0, in_col} == w_m1) begin
                in_col  <= '0;
                in_row  <= in_row + 1'b1;
                in_slot <= (in_slot == SLOT_W'(SLOTS - 1)) ? '0 : in_slot + 1'b1;
              end else begin
                in_col <= in_col + 1'b1;
              end
            end
          end
        end
        EMIT: begin
          if ((n < cap) && ready) begin
            if (!q_full) begin
              n <= n + 1'b1;
              if (out_last) begin
                // image done: every position starts over
                in_col   <= '0;
                in_row   <= '0;
                in_slot  <= '0;
                out_col  <= '0;
                out_row  <= '0;
                out_slot <= '0;
                state    <= IDLE;
              end else if ({1'b0, out_col} == w_m1) begin
                out_col  <= '0;
                out_row  <= out_row + 1'b1;
                out_slot <= (out_slot == SLOT_W'(SLOTS - 1)) ? '0 : out_slot + 1'b1;
              end else begin
                out_col <= out_col + 1'b1;
              end
            end
          end else begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/gws_back.sv]
// back part: line store, weighted window sum, rounding divide and output register
`timescale 1ns / 1ps
`default_nettype none
module gws_back (
  input  logic                              clk,
  input  logic                              rst,
  input  gws_pkg::wr_t                      wr,
  input  gws_pkg::geom_t                    geom,
  input  logic                              q_empty,
  input  gws_pkg::cmd_t                     q_data,
  output logic                              q_pop,
  output logic                              reading,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [gws_pkg::ELEV_W-1:0] smoothed,
  output logic                              out_nodata,
  output logic [gws_pkg::COL_W-1:0]         out_column,
  output logic [gws_pkg::ROW_W-1:0]         out_row,
  output logic                              is_last
);
  import gws_pkg::*;

  typedef enum logic [2:0] {IDLE, ACC, FLUSH, DIV, FINISH} state_t;

  localparam int R_W = ROW_W + 2;
  localparam int C_W = COL_W + 2;

  logic [CELL_W-1:0] line_store [SLOTS*MAX_WIDTH];

  state_t state;
  cmd_t   cmd;
  logic [TAP_W-1:0]  dy;
  logic [TAP_W-1:0]  dx;
  logic [SLOT_W-1:0] row_slot;

  logic              s1v;
  logic              s1_use;
  logic [K_W-1:0]    s1_k;
  logic [CELL_W-1:0] rd_cell;
  logic              s2v;
  logic signed [PROD_W-1:0] prod;
  logic [WGT_W-1:0]  pw;

  logic signed [SUM_W-1:0] sum;
  logic [WSUM_W-1:0] wsum;
  logic              neg;
  logic              nodata;
  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  dsh;
  logic [QUO_W-1:0]  quo;
  logic [STEP_W-1:0] step;

  logic signed [R_W-1:0] r_pos;
  logic signed [C_W-1:0] c_pos;
  logic              use_tap;
  logic [ADDR_W-1:0] rd_addr;
  logic [SLOT_W:0]   start_slot;
  logic              take;
  logic [WGT_W-1:0]  wt;
  logic [SUM_W-1:0]  mag;
  logic              out_free;

  always_comb begin
    r_pos   = signed'(R_W'(cmd.row)) + signed'(R_W'(dy)) - signed'(R_W'(WINDOW_RADIUS));
    c_pos   = signed'(C_W'(cmd.col)) + signed'(C_W'(dx)) - signed'(C_W'(WINDOW_RADIUS));
    use_tap = !r_pos[R_W-1] && (r_pos < signed'(R_W'(geom.h_eff)))
           && !c_pos[C_W-1] && (c_pos < signed'(C_W'(geom.w_eff)));
    rd_addr = {row_slot, c_pos[COL_W-1:0]};
  end

  // slot of the top window row, that is the center slot minus the radius
  always_comb begin
    start_slot = (SLOT_W + 1)'(q_data.slot) + (SLOT_W + 1)'(SLOTS - WINDOW_RADIUS);
    if (start_slot >= (SLOT_W + 1)'(SLOTS)) start_slot = start_slot - (SLOT_W + 1)'(SLOTS);
  end

  assign take     = s1v && s1_use && rd_cell[CELL_W-1];
  assign wt       = WEIGHT[s1_k];
  assign mag      = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign q_pop    = (state == IDLE) && !q_empty;
  assign reading  = (state == ACC);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (wr.en) line_store[wr.addr] <= wr.word;
  end

  always_ff @(posedge clk) begin
    rd_cell <= line_store[rd_addr];
  end

  // tap pipeline: address, weight and product
  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
      s2v <= 1'b0;
    end else begin
      s1v <= (state == ACC);
      s2v <= s1v;
    end
    s1_use <= use_tap;
    s1_k   <= K_W'(off_sq(dx) + off_sq(dy));
    prod   <= take ? signed'(PROD_W'(signed'(rd_cell[ELEV_W-1:0])))
                     * signed'(PROD_W'({1'b0, wt})) : '0;
    pw     <= take ? wt : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      // a new result in the finish state takes over the output register itself
      if (out_valid && !out_stall && (state != FINISH)) out_valid <= 1'b0;
      if (s2v) begin
        sum  <= sum + SUM_W'(prod);
        wsum <= wsum + WSUM_W'(pw);
      end
      case (state)
        IDLE: begin
          if (!q_empty) begin
            cmd      <= q_data;
            dy       <= '0;
            dx       <= '0;
            row_slot <= start_slot[SLOT_W-1:0];
            sum      <= '0;
            wsum     <= '0;
            state    <= ACC;
          end
        end
        ACC: begin
          if (dx == TAP_W'(SLOTS - 1)) begin
            dx       <= '0;
            dy       <= dy + 1'b1;
            row_slot <= (row_slot == SLOT_W'(SLOTS - 1)) ? '0 : row_slot + 1'b1;
            if (dy == TAP_W'(SLOTS - 1)) state <= FLUSH;
          end else begin
            dx <= dx + 1'b1;
          end
        end
        FLUSH: begin
          if (!s1v && !s2v) begin
            neg    <= sum[SUM_W-1];
            nodata <= (wsum == '0);
            rem    <= NUM_W'({mag, 1'b0}) + NUM_W'(wsum);
            dsh    <= NUM_W'({wsum, 1'b0}) << (QUO_W - 1);
            quo    <= '0;
            step   <= '0;
            state  <= DIV;
          end
        end
        DIV: begin
          // restoring divide, one quotient bit a cycle
          if (rem >= dsh) begin
            rem <= rem - dsh;
            quo <= {quo[QUO_W-2:0], 1'b1};
          end else begin
            quo <= {quo[QUO_W-2:0], 1'b0};
          end
          dsh  <= dsh >> 1;
          step <= step + 1'b1;
          if (step == STEP_W'(QUO_W - 1)) state <= FINISH;
        end
        FINISH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            smoothed   <= nodata ? '0 : (neg ? -signed'(quo) : signed'(quo));
            out_nodata <= nodata;
            out_column <= cmd.col;
            out_row    <= cmd.row;
            is_last    <= cmd.last;
            state      <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/gaussian_window_smoothing.sv]
// top level of the gaussian window smoothing block
//
// elevation pixels enter in raster order on the input channel (in_valid / in_stall),
// each a pixel item (action 0) or a drain item (action 1). results leave in raster
// order on the output channel (out_valid / out_stall); a transfer happens at a clock
// edge with valid high and stall low. image_width and image_height are written
// through cfg_write / cfg_index / cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce; a write restarts the image.
// a pixel item schedules up to six ready results, a drain item one. each result
// reads its 11x11 window from the line store one cell a cycle (single read port),
// drains the multiply pipe and runs a restoring divide.
// in_stall stays high while results of the previous item are still scheduled or
// their window is being read. the output register holds a result while out_stall
// is high; the next result is computed meanwhile and waits behind it.
// synchronous reset (rst) clears the positions, restores 640x480 and empties the
// queue and output; the line store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module gaussian_window_smoothing (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [gws_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gws_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic signed [gws_pkg::ELEV_W-1:0] elevation,
  input  logic                              missing,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [gws_pkg::ELEV_W-1:0] smoothed,
  output logic                              out_nodata,
  output logic [gws_pkg::COL_W-1:0]         out_column,
  output logic [gws_pkg::ROW_W-1:0]         out_row,
  output logic                              is_last
);
  import gws_pkg::*;

  cmd_t  push_cmd;
  cmd_t  pop_cmd;
  wr_t   wr;
  geom_t geom;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  logic  reading;

  gws_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .elevation    (elevation),
    .missing      (missing),
    .back_reading (reading),
    .q_full       (q_full),
    .q_empty      (q_empty),
    .q_push       (q_push),
    .q_data       (push_cmd),
    .wr           (wr),
    .geom         (geom)
  );

  gws_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_cmd),
    .pop       (q_pop),
    .pop_data  (pop_cmd),
    .full      (q_full),
    .empty     (q_empty)
  );

  gws_back u_back (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .geom       (geom),
    .q_empty    (q_empty),
    .q_data     (pop_cmd),
    .q_pop      (q_pop),
    .reading    (reading),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .smoothed   (smoothed),
    .out_nodata (out_nodata),
    .out_column (out_column),
    .out_row    (out_row),
    .is_last    (is_last)
  );

endmodule
`default_nettype wire

[hdl/gws_checker.sv]
// port-level checker of the gaussian window smoothing block and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "gaussian_window_smoothing_assert.svh"
module gws_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cfg_write,
  input logic [gws_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [gws_pkg::CFG_DATA_W-1:0]    cfg_data,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              action,
  input logic signed [gws_pkg::ELEV_W-1:0] elevation,
  input logic                              missing,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [gws_pkg::ELEV_W-1:0] smoothed,
  input logic                              out_nodata,
  input logic [gws_pkg::COL_W-1:0]         out_column,
  input logic [gws_pkg::ROW_W-1:0]         out_row,
  input logic                              is_last
);

  // a result with no usable cell carries zero
  `GWS_ASSERT_NOW(a_nodata_zero, out_valid && out_nodata, smoothed == '0, "nodata result not zero")

  // out of reset nothing is pending and input is open
  `GWS_ASSERT_RESET(a_reset_clear, rst, !out_valid && !in_stall, "state not cleared by reset")

  // a waiting result holds still
  `GWS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(smoothed) && $stable(out_row) && $stable(out_column)
    && $stable(is_last), "stalled result changed")

endmodule

bind gaussian_window_smoothing gws_checker u_gws_checker (.*);
`default_nettype wire
